>>> sv/hsvrgb_pkg.sv
package hsvrgb_pkg;

    // fixed field widths
    localparam int HUE_W = 15;
    localparam int CH_W  = 16;
    localparam int REM_W = 12;

    // one sector is 60 degrees in 1/64 degree steps, 3840 = 15 * 2^8
    localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_TURN   = 15'd23040;
    localparam int SECTOR_SHIFT = 8;
    localparam int SECTOR_ODD   = 15;

    // reciprocal of 15 scaled by 2^24, truncated, so the estimate is low by at most one
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_15 = 21'd1118481;

    // estimate width: quotients stay below 2^17
    localparam int EST_W = 17;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,  // red max, green rising
        SEC_YG = 3'd1,  // green max, red falling
        SEC_GC = 3'd2,  // green max, blue rising
        SEC_CB = 3'd3,  // blue max, green falling
        SEC_BM = 3'd4,  // blue max, red rising
        SEC_MR = 3'd5   // red max, blue falling
    } sector_t;

endpackage

>>> sv/hsv_to_rgb_pixel_convert.sv
// channel   direction  handshake             fields
// in        input      in_valid / in_stall   hue[14:0], saturation[15:0], brightness[15:0]
// out       output     out_valid / out_stall red[15:0], green[15:0], blue[15:0]
//
// one item per clock sustained while out_stall is low, six register stages
// the depth is set by the two multiplier stages (s*f, then v*(1-s*f)) and the
// reciprocal multiply that replaces the divide by 15
// stages advance independently: a bubble inside the pipe still takes an item
// while the output register holds a stalled result
// rst_n clears the valid bits only; payload registers are not reset
module hsv_to_rgb_pixel_convert #(
    parameter int FRAC_BITS = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  hue,
    input  logic [hsvrgb_pkg::CH_W-1:0]   saturation,
    input  logic [hsvrgb_pkg::CH_W-1:0]   brightness,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hsvrgb_pkg::CH_W-1:0]   red,
    output logic [hsvrgb_pkg::CH_W-1:0]   green,
    output logic [hsvrgb_pkg::CH_W-1:0]   blue
);
    import hsvrgb_pkg::*;

    // 1.0 in the fixed-point format and its sector-scaled version
    localparam int ONE_W  = FRAC_BITS + 1;
    localparam logic [ONE_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int FULL_W = FRAC_BITS + REM_W;
    localparam logic [FULL_W-1:0] FULL = FULL_W'(HUE_SECTOR) << FRAC_BITS;
    // product widths
    localparam int SQ_W = CH_W + REM_W;       // s * remainder
    localparam int P_W  = CH_W + ONE_W;       // v * (1 - s)
    localparam int NQ_W = CH_W + FULL_W;      // v * (full - s * rem)
    localparam int M_W  = NQ_W + 1 - FRAC_BITS - SECTOR_SHIFT;
    localparam logic [P_W:0]  HALF_P = (P_W+1)'(ONE) >> 1;
    localparam logic [NQ_W:0] HALF_Q = (NQ_W+1)'(FULL) >> 1;

    // stage enables, each stage moves when empty or when the next one moves
    logic en1, en2, en3, en4, en5, en6;
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, vld6_reg;

    assign en6 = !vld6_reg || !out_stall;
    assign en5 = !vld5_reg || en6;
    assign en4 = !vld4_reg || en5;
    assign en3 = !vld3_reg || en4;
    assign en2 = !vld2_reg || en3;
    assign en1 = !vld1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end
        else
        begin
            if (en1) vld1_reg <= in_valid;
            if (en2) vld2_reg <= vld1_reg;
            if (en3) vld3_reg <= vld2_reg;
            if (en4) vld4_reg <= vld3_reg;
            if (en5) vld5_reg <= vld4_reg;
            if (en6) vld6_reg <= vld5_reg;
        end
    end

    // ---------------- stage 1: clamp, hue wrap, sector split
    logic [HUE_W-1:0] hue_wrap;
    sector_t          sec1_next;
    logic [HUE_W-1:0] base1;
    logic [CH_W-1:0]  sat1_next, val1_next;

    sector_t          sec1_reg;
    logic [REM_W-1:0] rem1_reg;
    logic [CH_W-1:0]  sat1_reg, val1_reg;

    always_comb
    begin
        // values above one saturate to one (only reachable when FRAC_BITS < 16)
        sat1_next = (32'(saturation) > 32'(ONE)) ? CH_W'(ONE) : saturation;
        val1_next = (32'(brightness) > 32'(ONE)) ? CH_W'(ONE) : brightness;
        // a full turn or more wraps once
        hue_wrap = (hue >= HUE_TURN) ? hue - HUE_TURN : hue;
        priority if (hue_wrap >= HUE_SECTOR * 15'd5)
        begin
            sec1_next = SEC_MR;
            base1     = HUE_SECTOR * 15'd5;
        end
        else if (hue_wrap >= HUE_SECTOR * 15'd4)
        begin
            sec1_next = SEC_BM;
            base1     = HUE_SECTOR * 15'd4;
        end
        else if (hue_wrap >= HUE_SECTOR * 15'd3)
        begin
            sec1_next = SEC_CB;
            base1     = HUE_SECTOR * 15'd3;
        end
        else if (hue_wrap >= HUE_SECTOR * 15'd2)
        begin
            sec1_next = SEC_GC;
            base1     = HUE_SECTOR * 15'd2;
        end
        else if (hue_wrap >= HUE_SECTOR)
        begin
            sec1_next = SEC_YG;
            base1     = HUE_SECTOR;
        end
        else
        begin
            sec1_next = SEC_RY;
            base1     = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            sec1_reg <= sec1_next;
            rem1_reg <= REM_W'(hue_wrap - base1);
            sat1_reg <= sat1_next;
            val1_reg <= val1_next;
        end
    end

    // ---------------- stage 2: s*f and s*(1-f), 1-s
    sector_t          sec2_reg;
    logic [CH_W-1:0]  val2_reg;
    logic [ONE_W-1:0] oms2_reg;
    logic [SQ_W-1:0]  sq2_reg, st2_reg;

    always_ff @(posedge clk)
    begin
        if (en2 && vld1_reg)
        begin
            sec2_reg <= sec1_reg;
            val2_reg <= val1_reg;
            oms2_reg <= ONE - ONE_W'(sat1_reg);
            sq2_reg  <= SQ_W'(sat1_reg) * SQ_W'(rem1_reg);
            st2_reg  <= SQ_W'(sat1_reg) * SQ_W'(REM_W'(HUE_SECTOR) - rem1_reg);
        end
    end

    // ---------------- stage 3: scale by v
    // with zero saturation all three products reduce to v, which gives grey
    sector_t         sec3_reg;
    logic [CH_W-1:0] val3_reg;
    logic [P_W-1:0]  pp3_reg;
    logic [NQ_W-1:0] pq3_reg, pt3_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && vld2_reg)
        begin
            sec3_reg <= sec2_reg;
            val3_reg <= val2_reg;
            pp3_reg  <= P_W'(val2_reg) * P_W'(oms2_reg);
            pq3_reg  <= NQ_W'(val2_reg) * NQ_W'(FULL - FULL_W'(sq2_reg));
            pt3_reg  <= NQ_W'(val2_reg) * NQ_W'(FULL - FULL_W'(st2_reg));
        end
    end

    // ---------------- stage 4: round, drop the power-of-two part of the divisor
    logic [P_W:0]  pr4;
    logic [NQ_W:0] qr4, tr4;

    sector_t         sec4_reg;
    logic [CH_W-1:0] val4_reg, p4_reg;
    logic [M_W-1:0]  mq4_reg, mt4_reg;

    assign pr4 = (P_W+1)'(pp3_reg) + HALF_P;
    assign qr4 = (NQ_W+1)'(pq3_reg) + HALF_Q;
    assign tr4 = (NQ_W+1)'(pt3_reg) + HALF_Q;

    always_ff @(posedge clk)
    begin
        if (en4 && vld3_reg)
        begin
            sec4_reg <= sec3_reg;
            val4_reg <= val3_reg;
            p4_reg   <= pr4[FRAC_BITS +: CH_W];
            mq4_reg  <= qr4[NQ_W -: M_W];
            mt4_reg  <= tr4[NQ_W -: M_W];
        end
    end

    // ---------------- stage 5: divide by 15 via reciprocal estimate
    logic [M_W+RECIP_W-1:0] eq5_full, et5_full;

    sector_t          sec5_reg;
    logic [CH_W-1:0]  val5_reg, p5_reg;
    logic [M_W-1:0]   mq5_reg, mt5_reg;
    logic [EST_W-1:0] eq5_reg, et5_reg;

    assign eq5_full = (M_W+RECIP_W)'(mq4_reg) * (M_W+RECIP_W)'(RECIP_15);
    assign et5_full = (M_W+RECIP_W)'(mt4_reg) * (M_W+RECIP_W)'(RECIP_15);

    always_ff @(posedge clk)
    begin
        if (en5 && vld4_reg)
        begin
            sec5_reg <= sec4_reg;
            val5_reg <= val4_reg;
            p5_reg   <= p4_reg;
            mq5_reg  <= mq4_reg;
            mt5_reg  <= mt4_reg;
            eq5_reg  <= eq5_full[RECIP_SHIFT +: EST_W];
            et5_reg  <= et5_full[RECIP_SHIFT +: EST_W];
        end
    end

    // ---------------- stage 6: fix the estimate, route by sector
    logic [M_W-1:0]  rq6, rt6;
    logic [CH_W-1:0] q6, t6;
    logic [CH_W-1:0] red_next, green_next, blue_next;

    logic [CH_W-1:0] red_reg, green_reg, blue_reg, val6_reg;

    always_comb
    begin
        rq6 = mq5_reg - M_W'(eq5_reg) * M_W'(SECTOR_ODD);
        rt6 = mt5_reg - M_W'(et5_reg) * M_W'(SECTOR_ODD);
        q6  = (rq6 >= M_W'(SECTOR_ODD)) ? CH_W'(eq5_reg + EST_W'(1)) : CH_W'(eq5_reg);
        t6  = (rt6 >= M_W'(SECTOR_ODD)) ? CH_W'(et5_reg + EST_W'(1)) : CH_W'(et5_reg);
        unique case (sec5_reg)
            SEC_RY:
            begin
                red_next = val5_reg; green_next = t6;       blue_next = p5_reg;
            end
            SEC_YG:
            begin
                red_next = q6;       green_next = val5_reg; blue_next = p5_reg;
            end
            SEC_GC:
            begin
                red_next = p5_reg;   green_next = val5_reg; blue_next = t6;
            end
            SEC_CB:
            begin
                red_next = p5_reg;   green_next = q6;       blue_next = val5_reg;
            end
            SEC_BM:
            begin
                red_next = t6;       green_next = p5_reg;   blue_next = val5_reg;
            end
            default:
            begin
                red_next = val5_reg; green_next = p5_reg;   blue_next = q6;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en6 && vld5_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            val6_reg  <= val5_reg;
        end
    end

    assign out_valid = vld6_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // reciprocal estimate is low by at most one
    a_est_q: assert property (@(posedge clk) disable iff (!rst_n)
        vld5_reg |-> (mq5_reg - M_W'(eq5_reg) * M_W'(SECTOR_ODD)) < M_W'(2 * SECTOR_ODD))
        else $error("q quotient estimate off by more than one");

    a_est_t: assert property (@(posedge clk) disable iff (!rst_n)
        vld5_reg |-> (mt5_reg - M_W'(et5_reg) * M_W'(SECTOR_ODD)) < M_W'(2 * SECTOR_ODD))
        else $error("t quotient estimate off by more than one");

    // one channel always carries the value
    a_max_chan: assert property (@(posedge clk) disable iff (!rst_n)
        vld6_reg |-> (red_reg == val6_reg || green_reg == val6_reg || blue_reg == val6_reg))
        else $error("no channel equals brightness");

    // an empty first stage never pushes back
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !vld1_reg |-> !in_stall)
        else $error("input stalled with empty first stage");

    // a result waiting at the output keeps its valid, red and blue while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld6_reg && out_stall) |=> (vld6_reg && $stable(red_reg) && $stable(blue_reg)))
        else $error("stalled result changed");

endmodule

>>> tb/tb.sv
module tb;

    import hsvrgb_pkg::*;

    // converter is built at its default fraction width, 32768 = 1.0
    localparam int          FRAC_BITS = 15;
    localparam logic [63:0] UNIT      = 64'd1 << FRAC_BITS;

    // item counts and run limits
    localparam int DIR_N      = 23;
    localparam int RAND_N     = 930;
    localparam int DRAIN_CYC  = 20;   // pipe is six deep, leave room for strays
    localparam int QUIET_MAX  = 2000; // cycles with no transfer on either side
    localparam int HOLD_CYC   = 300;  // long receiver hold-off
    localparam int HOLD_AT    = 250;  // pixels in before the hold-off starts
    localparam int CALM_LO    = 480;  // window with no idling on either side
    localparam int CALM_HI    = 680;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // one stimulus row; typed rows carry a hand-worked result
    typedef struct packed {
        logic [HUE_W-1:0] h;
        logic [CH_W-1:0]  s;
        logic [CH_W-1:0]  v;
        logic             typed;
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
    } pix_row_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [HUE_W-1:0]  hue        = '0;
    logic [CH_W-1:0]   saturation = '0;
    logic [CH_W-1:0]   brightness = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;

    // rgb values still owed by the converter, oldest first
    rgb_t pending_rgb[$];
    // result for the pixel currently on the input port
    rgb_t cur_rgb = '0;

    int mismatches     = 0;
    int pixels_in      = 0;
    int pixels_out     = 0;
    int grey_pixels    = 0;
    int wrapped_pixels = 0;
    int backpressure   = 0;
    int quiet_cycles   = 0;

    // directed rows: black, grey, the six primary and secondary corners,
    // the full-turn wrap, hue past a full turn, saturation and brightness
    // above one, sector edges and alternating bit patterns
    pix_row_t directed_rows [DIR_N] = '{
        '{15'd0,     16'd0,     16'd0,     1'b1, 16'd0,     16'd0,     16'd0    },
        '{15'd0,     16'd0,     16'd32768, 1'b1, 16'd32768, 16'd32768, 16'd32768},
        '{15'd12345, 16'd0,     16'd20000, 1'b1, 16'd20000, 16'd20000, 16'd20000},
        '{15'd0,     16'd32768, 16'd32768, 1'b1, 16'd32768, 16'd0,     16'd0    },
        '{15'd3840,  16'd32768, 16'd32768, 1'b1, 16'd32768, 16'd32768, 16'd0    },
        '{15'd7680,  16'd32768, 16'd32768, 1'b1, 16'd0,     16'd32768, 16'd0    },
        '{15'd11520, 16'd32768, 16'd32768, 1'b1, 16'd0,     16'd32768, 16'd32768},
        '{15'd15360, 16'd32768, 16'd32768, 1'b1, 16'd0,     16'd0,     16'd32768},
        '{15'd19200, 16'd32768, 16'd32768, 1'b1, 16'd32768, 16'd0,     16'd32768},
        '{15'd23040, 16'd32768, 16'd32768, 1'b1, 16'd32768, 16'd0,     16'd0    },
        '{15'd32767, 16'd65535, 16'd65535, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd5000,  16'd65535, 16'd0,     1'b1, 16'd0,     16'd0,     16'd0    },
        '{15'd32767, 16'd0,     16'd65535, 1'b1, 16'd32768, 16'd32768, 16'd32768},
        '{15'd3839,  16'd32768, 16'd32768, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd23039, 16'd32768, 16'd32768, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd23041, 16'd32768, 16'd32768, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd1920,  16'd16384, 16'd32768, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd10000, 16'd1,     16'd65535, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd20000, 16'd32769, 16'd12345, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd7679,  16'd1,     16'd1,     1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd16000, 16'd40000, 16'd50000, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd10922, 16'd21845, 16'd43690, 1'b0, 16'd0,     16'd0,     16'd0    },
        '{15'd21845, 16'd43690, 16'd21845, 1'b0, 16'd0,     16'd0,     16'd0    }
    };

    hsv_to_rgb_pixel_convert #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #10 clk = ~clk;

    // hexcone conversion with exact products and one rounded divide each
    function automatic rgb_t hsv_to_rgb_model(
        input logic [HUE_W-1:0] h_in,
        input logic [CH_W-1:0]  s_in,
        input logic [CH_W-1:0]  v_in
    );
        logic [63:0] hh, ss, vv, rem, span, lo, fall, rise;
        logic [63:0] rr, gg, bb;
        sector_t     sec;
        rgb_t        res;
        hh = 64'(h_in);
        ss = (64'(s_in) > UNIT) ? UNIT : 64'(s_in);
        vv = (64'(v_in) > UNIT) ? UNIT : 64'(v_in);
        // a full turn or more folds back once
        if (hh >= HUE_TURN)
            hh = hh - HUE_TURN;
        if (ss == 0)
        begin
            rr = vv;
            gg = vv;
            bb = vv;
        end
        else
        begin
            sec  = sector_t'(3'(hh / HUE_SECTOR));
            rem  = hh - (hh / HUE_SECTOR) * HUE_SECTOR;
            span = UNIT * HUE_SECTOR;
            lo   = (vv * (UNIT - ss) + (UNIT >> 1)) / UNIT;
            fall = (vv * (span - ss * rem) + (span >> 1)) / span;
            rise = (vv * (span - ss * (HUE_SECTOR - rem)) + (span >> 1)) / span;
            case (sec)
                SEC_RY:
                begin
                    rr = vv;   gg = rise; bb = lo;
                end
                SEC_YG:
                begin
                    rr = fall; gg = vv;   bb = lo;
                end
                SEC_GC:
                begin
                    rr = lo;   gg = vv;   bb = rise;
                end
                SEC_CB:
                begin
                    rr = lo;   gg = fall; bb = vv;
                end
                SEC_BM:
                begin
                    rr = rise; gg = lo;   bb = vv;
                end
                default:
                begin
                    rr = vv;   gg = lo;   bb = fall;
                end
            endcase
        end
        res.r = rr[CH_W-1:0];
        res.g = gg[CH_W-1:0];
        res.b = bb[CH_W-1:0];
        return res;
    endfunction

    // put one pixel on the input at a falling edge and hold it until taken;
    // returns at the falling edge after acceptance
    task automatic offer_pixel(input pix_row_t row, input bit calm);
        if (!calm)
            while ($urandom_range(0, 99) < 25)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid   <= 1'b1;
        hue        <= row.h;
        saturation <= row.s;
        brightness <= row.v;
        if (row.typed)
        begin
            cur_rgb.r = row.r;
            cur_rgb.g = row.g;
            cur_rgb.b = row.b;
        end
        else
            cur_rgb = hsv_to_rgb_model(row.h, row.s, row.v);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls, one long hold-off to back the pipe up,
    // and a calm window with no stalls at all
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && pixels_in >= HOLD_AT)
            begin
                hold_left = HOLD_CYC;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (pixels_in >= CALM_LO && pixels_in < CALM_HI)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    // scoreboard: results are checked before the input of the same edge is
    // queued, so a result can never be matched to a pixel taken that cycle
    always @(posedge clk)
    begin : scoreboard
        rgb_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                pixels_out++;
                if (pending_rgb.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result r=%0d g=%0d b=%0d", red, green, blue);
                    mismatches++;
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    if (red !== want.r || green !== want.g || blue !== want.b)
                    begin
                        if (mismatches < 10)
                            $display("result %0d: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     pixels_out, want.r, want.g, want.b, red, green, blue);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_rgb.insert(pending_rgb.size(), cur_rgb);
                pixels_in++;
                if (saturation == 0)
                    grey_pixels++;
                if (hue >= HUE_TURN)
                    wrapped_pixels++;
            end
            else if (in_valid)
                backpressure++;
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int       k;
        int       edge_hue;
        pix_row_t row;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < DIR_N; k++)
            offer_pixel(directed_rows[k], 1'b0);

        row = '0;
        for (k = 0; k < RAND_N; k++)
        begin
            // hue: mostly in range, some on sector edges, some past a full turn
            case ($urandom_range(0, 9))
                0:
                begin
                    edge_hue = $urandom_range(0, 6) * HUE_SECTOR + $urandom_range(0, 2) - 1;
                    row.h    = edge_hue[HUE_W-1:0];
                end
                1:       row.h = HUE_W'($urandom_range(HUE_TURN, 32767));
                2:       row.h = HUE_W'($urandom_range(0, 32767));
                default: row.h = HUE_W'($urandom_range(0, HUE_TURN - 1));
            endcase
            // saturation and brightness: zero, one, in range, or anything
            case ($urandom_range(0, 9))
                0:       row.s = '0;
                1:       row.s = UNIT[CH_W-1:0];
                2, 3:    row.s = CH_W'($urandom_range(0, 65535));
                default: row.s = CH_W'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 9))
                0:       row.v = '0;
                1:       row.v = UNIT[CH_W-1:0];
                2, 3:    row.v = CH_W'($urandom_range(0, 65535));
                default: row.v = CH_W'($urandom_range(0, 32768));
            endcase
            offer_pixel(row, (pixels_in >= CALM_LO && pixels_in < CALM_HI));
        end
        in_valid <= 1'b0;

        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("converted %0d pixels (%0d directed), %0d grey, %0d with hue past a full turn",
                 pixels_in, DIR_N, grey_pixels, wrapped_pixels);
        $display("input held off %0d cycles, %0d bad results, %0d results missing",
                 backpressure, mismatches, pending_rgb.size());
        if (mismatches == 0 && pending_rgb.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
sv/hsvrgb_pkg.sv
sv/hsv_to_rgb_pixel_convert.sv
tb/tb.sv
